### rtl/core/gdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Graph walk package
// Shared types, sizes and helper functions for the depth-first walk unit.
// ----------------------------------------------------------------------------
package gdc_pkg;

   // Graph size and derived storage sizes.
   localparam int NUM_VERTICES = 16;
   localparam int ROW_W        = 16;
   localparam int VERTEX_W     = 4;
   localparam int DEGREE_W     = 5;
   localparam int STACK_DEPTH  = NUM_VERTICES * NUM_VERTICES;
   localparam int SP_W         = $clog2(STACK_DEPTH);
   localparam int CNT_W        = $clog2(STACK_DEPTH + 1);

   // Row bits at or above the vertex count are dropped on load.
   localparam logic [ROW_W-1:0] ROW_MASK = (NUM_VERTICES >= ROW_W) ? {ROW_W{1'b1}} :
      ROW_W'((64'd1 << NUM_VERTICES) - 64'd1);

   // Command codes of the input word.
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [VERTEX_W-1:0] row_index;
      logic [ROW_W-1:0]    row_bits;
      logic [VERTEX_W-1:0] start_vertex;
   } req_word_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [DEGREE_W-1:0] degree;
      logic                last;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_row;
      logic start_walk;
      logic pop;
      logic visit;
      logic push;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic cand_skip;
      logic mask_zero;
      logic held_valid;
      logic out_free;
   } status_type;

   // True when a vertex number lies inside the graph.
   function automatic logic vertex_in_range(input logic [VERTEX_W-1:0] v);
      logic [31:0] wide;
      wide = {{(32-VERTEX_W){1'b0}}, v};
      return wide < 32'(NUM_VERTICES);
   endfunction

   // Number of set bits in a row.
   function automatic logic [DEGREE_W-1:0] count_bits(input logic [ROW_W-1:0] row);
      logic [DEGREE_W-1:0] n;
      n = '0;
      for (int i = 0; i < ROW_W; i++) begin
         n = n + DEGREE_W'(row[i]);
      end
      return n;
   endfunction

endpackage : gdc_pkg
`default_nettype wire

### rtl/core/gdc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Walk controller
// State machine that sequences loads, stack pops, visits and neighbor pushes.
// ----------------------------------------------------------------------------
module gdc_ctrl
   import gdc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_kind,
   output logic              req_ready,
   input  wire status_type   status,
   output cmd_type           cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_READ,
      ST_CHECK,
      ST_PUSH,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_kind == KIND_START) begin
                  cmd.start_walk = 1'b1;
                  state_in       = ST_POP;
               end else begin
                  cmd.load_row = 1'b1;
               end
            end
         end
         ST_POP: begin
            if (status.count_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // The popped word comes back from the stack memory through its read register.
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.cand_skip) begin
               state_in = ST_POP;
            end else if (!status.held_valid || status.out_free) begin
               cmd.visit = 1'b1;
               state_in  = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (status.mask_zero) begin
               state_in = ST_POP;
            end else begin
               cmd.push = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!status.held_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : gdc_ctrl
`default_nettype wire

### rtl/core/gdc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Walk datapath
// Adjacency rows, visited marks, pending stack memory, held result and the
// output register.
// ----------------------------------------------------------------------------
module gdc_dpath
   import gdc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_word_type req_word,
   input  wire cmd_type      cmd,
   output status_type        status,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   logic [ROW_W-1:0]    adj_ff [ROW_W];
   logic [ROW_W-1:0]    visited_ff;
   logic [VERTEX_W-1:0] stack_mem [STACK_DEPTH];
   logic [VERTEX_W-1:0] rd_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [ROW_W-1:0]    mask_ff;
   logic [VERTEX_W-1:0] held_vertex_ff;
   logic [DEGREE_W-1:0] held_degree_ff;
   logic                held_valid_ff;
   rsp_word_type        rsp_ff;
   logic                rsp_valid_ff;

   logic [ROW_W-1:0]    cand_row;
   logic [ROW_W-1:0]    mask_in;
   logic [VERTEX_W-1:0] pick_idx;
   logic [CNT_W-1:0]    pop_cnt;
   logic                start_ok;
   logic                stack_wr;
   logic [SP_W-1:0]     stack_waddr;
   logic [VERTEX_W-1:0] stack_wdata;
   logic                out_free;

   // Candidate row and the neighbors still to be pushed.
   assign cand_row = adj_ff[rd_ff];
   assign mask_in  = cand_row & ~(visited_ff | (ROW_W'(1) << rd_ff));
   assign pop_cnt  = count_ff - CNT_W'(1);
   assign start_ok = vertex_in_range(req_word.start_vertex);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Lowest pending neighbor goes first.
   always_comb begin
      pick_idx = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick_idx = VERTEX_W'(i);
         end
      end
   end

   // Stack write port: the start vertex or a neighbor.
   always_comb begin
      stack_wr    = 1'b0;
      stack_waddr = count_ff[SP_W-1:0];
      stack_wdata = pick_idx;
      if (cmd.start_walk) begin
         stack_wr    = start_ok;
         stack_waddr = '0;
         stack_wdata = req_word.start_vertex;
      end else if (cmd.push) begin
         stack_wr = (count_ff < CNT_W'(STACK_DEPTH));
      end
   end

   // Pending stack memory with registered read data.
   always_ff @(posedge clock) begin
      if (stack_wr) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (cmd.pop) begin
         rd_ff <= stack_mem[pop_cnt[SP_W-1:0]];
      end
   end

   // Adjacency rows.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_W; i++) begin
            adj_ff[i] <= '0;
         end
      end else if (cmd.load_row && vertex_in_range(req_word.row_index)) begin
         adj_ff[req_word.row_index] <= req_word.row_bits & ROW_MASK;
      end
   end

   // Visited marks, stack count and neighbor mask.
   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         count_ff   <= '0;
         mask_ff    <= '0;
      end else begin
         if (cmd.start_walk) begin
            visited_ff <= '0;
            count_ff   <= start_ok ? CNT_W'(1) : '0;
         end else if (cmd.pop) begin
            count_ff <= pop_cnt;
         end else if (stack_wr) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.visit) begin
            visited_ff[rd_ff] <= 1'b1;
            mask_ff           <= mask_in;
         end else if (cmd.push) begin
            mask_ff[pick_idx] <= 1'b0;
         end
      end
   end

   // The newest visited vertex waits here until the walk knows if it is last.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (cmd.start_walk || cmd.finish) begin
         held_valid_ff <= 1'b0;
      end else if (cmd.visit) begin
         held_valid_ff <= 1'b1;
      end
      if (cmd.visit) begin
         held_vertex_ff <= rd_ff;
         held_degree_ff <= count_bits(cand_row);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.visit && held_valid_ff) || cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if ((cmd.visit && held_valid_ff) || cmd.finish) begin
         rsp_ff.vertex <= held_vertex_ff;
         rsp_ff.degree <= held_degree_ff;
         rsp_ff.last   <= cmd.finish;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Status back to the controller.
   assign status.count_zero = (count_ff == '0);
   assign status.cand_skip  = !vertex_in_range(rd_ff) || visited_ff[rd_ff];
   assign status.mask_zero  = (mask_ff == '0);
   assign status.held_valid = held_valid_ff;
   assign status.out_free   = out_free;

endmodule : gdc_dpath
`default_nettype wire

### rtl/core/graph_dfs_with_degree_count_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth-first walk with degree count
// Loads an adjacency bit matrix and walks it depth first from a start vertex.
// ----------------------------------------------------------------------------
// A load word stores one adjacency row and returns nothing. A start word
// clears the visited marks and walks the graph with an explicit stack,
// returning one word per visited vertex (vertex, row bit count) with last
// set on the final one. The walk runs on one single-port stack memory:
// each pop goes through address, registered read and check, a newly
// visited vertex then pushes its unvisited neighbors one by one, and the
// walk ends by finding the stack empty and releasing the final word. The
// walk also waits while a word must go out and the output register is
// not free. No new word is accepted until the walk is done; a finished
// result may still sit in the output register.
// ----------------------------------------------------------------------------
module graph_dfs_with_degree_count_unit
   import gdc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   cmd_type    cmd;
   status_type status;

   gdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_word.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gdc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // A new word is only taken once the previous walk has released its result.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.held_valid)
      else $error("input accepted while a walk result is still held");

   // The output register is never overwritten while its word is waiting.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || (cmd.visit && status.held_valid)) |-> status.out_free)
      else $error("output register overwritten");

   // The final word always carries a held vertex.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.held_valid)
      else $error("final word without a visited vertex");

   // A push only happens while neighbors are pending.
   assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !status.mask_zero)
      else $error("push with no pending neighbor");

endmodule : graph_dfs_with_degree_count_unit
`default_nettype wire

### tb/graph_dfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-first walk checker
// Watches the request and result channels of the walk unit. It keeps its own
// copy of the adjacency rows, works out the visit words of every walk and
// compares each result word with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module graph_dfs_checker
   import gdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_word,
   output int           error_count,
   output int           pending_count,
   output int           load_count,
   output int           walk_count,
   output int           visit_count,
   output int           revisit_count
);

   // Predicted graph and the visit words still owed by the unit.
   logic [ROW_W-1:0] adj_rows [NUM_VERTICES];
   rsp_word_type     expected_visits [$];

   int mismatches    = 0;
   int loads_seen    = 0;
   int walks_seen    = 0;
   int visits_seen   = 0;
   int revisits_seen = 0;

   initial begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
         adj_rows[i] = '0;
      end
   end

   // Reports one wrong field of a visit word.
   task automatic report_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
      mismatches++;
      $display("%0t ns: visit word %0d, %s mismatch: expected %0d, actual %0d",
               $time, visits_seen, field, want, got);
   endtask

   // Walks the stored graph depth first from one vertex and queues the visit
   // words. Already visited vertices may sit on the stack more than once and
   // are skipped when popped.
   task automatic predict_walk(input logic [VERTEX_W-1:0] origin);
      logic [VERTEX_W-1:0]     stack_mem [STACK_DEPTH];
      logic [NUM_VERTICES-1:0] seen;
      logic [VERTEX_W-1:0]     v;
      logic [ROW_W-1:0]        row;
      rsp_word_type            word;
      int                      depth;
      int                      emitted;
      int                      j;
      seen    = '0;
      depth   = 0;
      emitted = 0;
      if (int'(origin) >= NUM_VERTICES) begin
         return;
      end
      stack_mem[0] = origin;
      depth = 1;
      while (depth > 0) begin
         depth--;
         v = stack_mem[depth];
         if (int'(v) >= NUM_VERTICES || seen[v]) begin
            revisits_seen++;
            continue;
         end
         seen[v] = 1'b1;
         row = adj_rows[v];
         // Unvisited neighbors go on the stack in increasing order.
         for (j = 0; j < ROW_W && j < NUM_VERTICES; j++) begin
            if (row[j] && !seen[j] && depth < STACK_DEPTH) begin
               stack_mem[depth] = VERTEX_W'(j);
               depth++;
            end
         end
         if (emitted < ROW_W) begin
            word.vertex = v;
            word.degree = DEGREE_W'($countones(row));
            word.last   = 1'b0;
            expected_visits.push_back(word);
            emitted++;
         end
      end
      // The final visit of the walk carries the last flag.
      if (emitted > 0) begin
         word = expected_visits.pop_back();
         word.last = 1'b1;
         expected_visits.push_back(word);
      end
   endtask

   // Both channels are sampled at the rising edge, before any update.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         expected_visits.delete();
         for (int i = 0; i < NUM_VERTICES; i++) begin
            adj_rows[i] = '0;
         end
      end else begin
         // Result words are checked against the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            if (expected_visits.size() == 0) begin
               mismatches++;
               $display("%0t ns: unexpected visit word: expected none, actual %0d/%0d/%0d",
                        $time, rsp_word.vertex, rsp_word.degree, rsp_word.last);
            end else begin
               want = expected_visits.pop_front();
               if (rsp_word.vertex !== want.vertex) begin
                  report_field("vertex", 16'(want.vertex), 16'(rsp_word.vertex));
               end
               if (rsp_word.degree !== want.degree) begin
                  report_field("degree", 16'(want.degree), 16'(rsp_word.degree));
               end
               if (rsp_word.last !== want.last) begin
                  report_field("last", 16'(want.last), 16'(rsp_word.last));
               end
               visits_seen++;
            end
         end
         // Accepted request words update the predicted graph or start a walk.
         if (req_valid && req_ready) begin
            if (req_word.kind == KIND_LOAD) begin
               loads_seen++;
               if (int'(req_word.row_index) < NUM_VERTICES) begin
                  adj_rows[req_word.row_index] = req_word.row_bits & ROW_MASK;
               end
            end else begin
               walks_seen++;
               predict_walk(req_word.start_vertex);
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_visits.size();
      load_count    <= loads_seen;
      walk_count    <= walks_seen;
      visit_count   <= visits_seen;
      revisit_count <= revisits_seen;
   end

endmodule : graph_dfs_checker

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-first walk unit testbench
// Loads a series of graphs of different shapes into the walk unit, starts
// walks from random vertices, and stalls both channels at random. A checker
// beside the unit predicts and compares every visit word.
// ----------------------------------------------------------------------------
module tb_top;
   import gdc_pkg::*;

   typedef enum int {
      SHAPE_EMPTY,
      SHAPE_SPARSE,
      SHAPE_DENSE,
      SHAPE_CHAIN,
      SHAPE_TREE,
      SHAPE_FULL,
      SHAPE_RANDOM,
      SHAPE_COUNT
   } graph_shape_type;

   localparam int    WORD_TARGET  = 400;
   localparam int    HOLD_CYCLES  = 300;
   localparam int    HOLD_FIRST   = 30;
   localparam int    HOLD_SECOND  = 250;
   localparam int    DRAIN_CYCLES = 40;
   localparam longint RUN_LIMIT_NS = 64'd40_000_000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   int error_count;
   int pending_count;
   int load_count;
   int walk_count;
   int visit_count;
   int revisit_count;

   int words_sent = 0;
   int holds_done = 0;
   bit send_calm  = 1'b0;

   graph_dfs_with_degree_count_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   graph_dfs_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .error_count   (error_count),
      .pending_count (pending_count),
      .load_count    (load_count),
      .walk_count    (walk_count),
      .visit_count   (visit_count),
      .revisit_count (revisit_count)
   );

   // Clock and a single reset pulse at the start.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Idle gap in cycles: mostly none or short, now and then long.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // One adjacency row of a graph of the given shape.
   function automatic logic [ROW_W-1:0] shape_row(input graph_shape_type shape, input int v);
      logic [ROW_W-1:0] row;
      row = '0;
      case (shape)
         SHAPE_EMPTY: begin
            row = '0;
         end
         SHAPE_SPARSE: begin
            if ($urandom_range(0, 3) != 0) row[$urandom_range(0, ROW_W - 1)] = 1'b1;
            if ($urandom_range(0, 2) == 0) row[$urandom_range(0, ROW_W - 1)] = 1'b1;
         end
         SHAPE_DENSE: begin
            row = ROW_W'($urandom | $urandom);
         end
         SHAPE_CHAIN: begin
            row[(v + 1) % ROW_W] = 1'b1;
            if ($urandom_range(0, 3) == 0) row[$urandom_range(0, v)] = 1'b1;
         end
         SHAPE_TREE: begin
            if (2 * v + 1 < ROW_W) row[2 * v + 1] = 1'b1;
            if (2 * v + 2 < ROW_W) row[2 * v + 2] = 1'b1;
         end
         SHAPE_FULL: begin
            row = '1;
         end
         default: begin
            row = ROW_W'($urandom);
         end
      endcase
      // Self-loops come and go at random.
      if ($urandom_range(0, 7) == 0) row[v] = ~row[v];
      return row;
   endfunction

   // Request words; the fields a command does not use carry random bits.
   function automatic req_word_type load_word(input int idx, input logic [ROW_W-1:0] bits);
      req_word_type w;
      w.kind         = KIND_LOAD;
      w.row_index    = VERTEX_W'(idx);
      w.row_bits     = bits;
      w.start_vertex = VERTEX_W'($urandom);
      return w;
   endfunction

   function automatic req_word_type start_word(input int v);
      req_word_type w;
      w.kind         = KIND_START;
      w.row_index    = VERTEX_W'($urandom);
      w.row_bits     = ROW_W'($urandom);
      w.start_vertex = VERTEX_W'(v);
      return w;
   endfunction

   // Offers one request word after an optional gap and waits until it is taken.
   task automatic send_word(input req_word_type w);
      int gap;
      gap = send_calm ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Result side: random stalls, calm stretches and two long holds that
   // back the walk up into the request channel.
   initial begin
      int  taken;
      int  stall;
      bit  calm;
      taken = 0;
      stall = 0;
      calm  = 1'b0;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_valid && rsp_ready) begin
            taken++;
            if ($urandom_range(0, 49) == 0) calm = ~calm;
            stall = calm ? 0 : idle_gap();
            if (taken == HOLD_FIRST || taken == HOLD_SECOND) begin
               stall = HOLD_CYCLES;
               holds_done++;
            end
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Request side: directed graphs first, then random graphs and walks.
   initial begin
      int              order [NUM_VERTICES];
      int              i;
      int              k;
      int              t;
      graph_shape_type shape;
      req_valid = 1'b0;
      req_word  = '0;
      do @(posedge clock); while (reset);

      // Empty graph: every walk is a lone vertex with no edges.
      send_word(start_word(0));
      send_word(start_word(NUM_VERTICES - 1));
      // A vertex joined to all others, and a top vertex with a self-loop.
      send_word(load_word(0, '1));
      send_word(load_word(NUM_VERTICES - 1, 16'h8001));
      send_word(start_word(0));
      send_word(start_word(NUM_VERTICES - 1));
      // Vertex 1 is pushed twice, so its second pop is skipped.
      send_word(load_word(0, 16'h0006));
      send_word(load_word(1, 16'h0000));
      send_word(load_word(2, 16'h0002));
      send_word(start_word(0));
      // Self-loop only, then a two-vertex cycle.
      send_word(load_word(5, 16'h0020));
      send_word(start_word(5));
      send_word(load_word(3, 16'h0010));
      send_word(load_word(4, 16'h0008));
      send_word(start_word(3));
      send_word(start_word(4));
      send_word(load_word(NUM_VERTICES - 1, 16'h0000));
      send_word(start_word(NUM_VERTICES - 1));

      // Mostly whole graphs in shuffled row order followed by walks; now and
      // then only a few rows are patched.
      while (words_sent < WORD_TARGET) begin
         shape = graph_shape_type'($urandom_range(0, SHAPE_COUNT - 1));
         send_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 8) begin
            for (i = 0; i < NUM_VERTICES; i++) begin
               order[i] = i;
            end
            for (i = NUM_VERTICES - 1; i > 0; i--) begin
               k = $urandom_range(0, i);
               t = order[i];
               order[i] = order[k];
               order[k] = t;
            end
            for (i = 0; i < NUM_VERTICES; i++) begin
               send_word(load_word(order[i], shape_row(shape, order[i])));
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               k = $urandom_range(0, NUM_VERTICES - 1);
               send_word(load_word(k, shape_row(shape, k)));
            end
         end
         repeat ($urandom_range(1, 3)) begin
            send_word(start_word($urandom_range(0, NUM_VERTICES - 1)));
         end
      end
      req_valid <= 1'b0;

      // Drain the remaining visit words, then allow a short quiet spell.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d row loads and %0d walks over random graph shapes.",
               load_count, walk_count);
      $display("Checked %0d visit words; %0d stale pops skipped; %0d long result holds.",
               visit_count, revisit_count, holds_done);
      if (error_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Timeout with %0d visit words outstanding.", pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule : tb_top
